FILE: sv/ghcc_pkg.sv
// ----------------------------------------------------------------------------
// ghcc_pkg
// Shared types, constants and calendar functions for the hour calendar counter.
// ----------------------------------------------------------------------------
package ghcc_pkg;

  typedef enum logic {
    MODE_TICK = 1'b0,
    MODE_LOAD = 1'b1
  } ghcc_mode_e;

  localparam int unsigned HourW  = 5;
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 16;

  localparam logic [HourW-1:0]  HourLast  = 5'd23;
  localparam logic [MonthW-1:0] MonthJan  = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb  = 4'd2;
  localparam logic [MonthW-1:0] MonthApr  = 4'd4;
  localparam logic [MonthW-1:0] MonthJun  = 4'd6;
  localparam logic [MonthW-1:0] MonthSep  = 4'd9;
  localparam logic [MonthW-1:0] MonthNov  = 4'd11;
  localparam logic [MonthW-1:0] MonthDec  = 4'd12;
  localparam logic [YearW-1:0]  YearFirst = 16'd1;
  localparam logic [YearW-1:0]  YearLast  = 16'hFFFF;

  // divisibility by 25 through the multiplicative inverse modulo 2^k
  localparam logic [13:0] Inv25W14 = 14'd7209;
  localparam logic [13:0] Lim25W14 = 14'd655;
  localparam logic [11:0] Inv25W12 = 12'd3113;
  localparam logic [11:0] Lim25W12 = 12'd163;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
    logic              leap;
  } ghcc_date_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } ghcc_load_t;

  function automatic logic leap_year(input logic [YearW-1:0] y);
    logic [13:0] p100;
    logic [11:0] p400;
    logic        div4;
    logic        div100;
    logic        div400;
    p100   = y[15:2] * Inv25W14;
    p400   = y[15:4] * Inv25W12;
    div4   = (y[1:0] == 2'd0);
    div100 = div4 && (p100 <= Lim25W14);
    div400 = (y[3:0] == 4'd0) && (p400 <= Lim25W12);
    return (div4 && !div100) || div400;
  endfunction

  function automatic logic [DayW-1:0] month_length(input logic [MonthW-1:0] m,
                                                   input logic              leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (m == MonthFeb) begin
      len = leap ? 5'd29 : 5'd28;
    end else if (m == MonthApr || m == MonthJun || m == MonthSep || m == MonthNov) begin
      len = 5'd30;
    end
    return len;
  endfunction

endpackage

FILE: sv/ghcc_step.sv
// ----------------------------------------------------------------------------
// ghcc_step
// Next-date logic: one-hour advance with rollovers, or a checked field load.
// ----------------------------------------------------------------------------
module ghcc_step (
  input  ghcc_pkg::ghcc_date_t date_i,
  input  logic                 mode_i,
  input  ghcc_pkg::ghcc_load_t load_i,
  output ghcc_pkg::ghcc_date_t date_o,
  output logic                 rejected_o
);
  import ghcc_pkg::*;

  logic              hour_roll;
  logic              day_roll;
  logic              month_roll;
  logic [YearW-1:0]  year_inc;
  logic [YearW-1:0]  year_sel;
  logic              leap_sel;
  logic              hour_ok;
  logic              day_ok;
  logic              month_ok;
  logic              year_ok;
  logic [MonthW-1:0] month_res;
  logic [DayW-1:0]   len_old;
  logic [DayW-1:0]   len_res;

  assign len_old    = month_length(date_i.month, date_i.leap);
  assign hour_roll  = (date_i.hour >= HourLast);
  assign day_roll   = (date_i.day >= len_old);
  assign month_roll = (date_i.month >= MonthDec);
  assign year_inc   = (date_i.year == YearLast) ? YearFirst : date_i.year + YearFirst;

  assign hour_ok  = (load_i.hour <= HourLast);
  assign year_ok  = (load_i.year != '0);
  assign month_ok = (load_i.month >= MonthJan) && (load_i.month <= MonthDec);

  // one leap unit: loaded year on a load (current year if the loaded one is rejected), following year on a tick
  assign year_sel  = (mode_i == MODE_LOAD) ? (year_ok ? load_i.year : date_i.year) : year_inc;
  assign leap_sel  = leap_year(year_sel);
  assign month_res = month_ok ? load_i.month : date_i.month;
  assign len_res   = month_length(month_res, leap_sel);
  assign day_ok    = (load_i.day != '0) && (load_i.day <= len_res);

  always_comb begin
    date_o     = date_i;
    rejected_o = 1'b0;
    unique case (mode_i)
      MODE_TICK: begin
        if (hour_roll) begin
          date_o.hour = '0;
          if (day_roll) begin
            date_o.day = 5'd1;
            if (month_roll) begin
              date_o.month = MonthJan;
              date_o.year  = year_inc;
              date_o.leap  = leap_sel;
            end else begin
              date_o.month = date_i.month + 4'd1;
            end
          end else begin
            date_o.day = date_i.day + 5'd1;
          end
        end else begin
          date_o.hour = date_i.hour + 5'd1;
        end
      end
      MODE_LOAD: begin
        if (hour_ok) date_o.hour = load_i.hour;
        date_o.year  = year_sel;
        date_o.leap  = leap_sel;
        date_o.month = month_res;
        if (day_ok) date_o.day = load_i.day;
        rejected_o = !(hour_ok && year_ok && month_ok && day_ok);
      end
      default: begin
        date_o     = date_i;
        rejected_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/gregorian_hour_calendar_counter.sv
// ----------------------------------------------------------------------------
// gregorian_hour_calendar_counter
// Hour, day, month and year counter with Gregorian leap years and checked load.
//
//   channel  | dir | tdata                                     | tuser
//   s_axis   | in  | hour 5, day 5, month 4, year 16, pad 2     | mode
//   m_axis   | out | hour 5, day 5, month 4, year 16, leap, rej | -
//
// one request per cycle sustained while the output is not stalled
// input register, then next-date logic into the date/result register
// the date register doubles as the result register and only moves when free
// reset gives 00h on 1 January of year 1 and empties both stages
// an output stall holds the result and backs up into the input register
// ----------------------------------------------------------------------------
module gregorian_hour_calendar_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,  // load_hour, load_day, load_month, load_year, zero pad
  input  logic        s_axis_tuser_i,  // mode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o   // cur_hour, cur_day, cur_month, cur_year, is_leap,
                                       // load_rejected
);
  import ghcc_pkg::*;

  logic       in_vld_q;
  logic       in_mode_q;
  ghcc_load_t in_load_q;
  logic       out_vld_q;
  logic       rej_q;
  ghcc_date_t date_q;
  ghcc_date_t date_d;
  logic       rej_d;
  logic       advance;
  logic       in_take;

  assign advance         = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || advance;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  ghcc_step u_step (
    .date_i     (date_q),
    .mode_i     (in_mode_q),
    .load_i     (in_load_q),
    .date_o     (date_d),
    .rejected_o (rej_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_mode_q       <= s_axis_tuser_i;
      in_load_q.hour  <= s_axis_tdata_i[4:0];
      in_load_q.day   <= s_axis_tdata_i[9:5];
      in_load_q.month <= s_axis_tdata_i[13:10];
      in_load_q.year  <= s_axis_tdata_i[29:14];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      rej_q        <= 1'b0;
      date_q.hour  <= '0;
      date_q.day   <= 5'd1;
      date_q.month <= MonthJan;
      date_q.year  <= YearFirst;
      date_q.leap  <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
      rej_q     <= rej_d;
      date_q    <= date_d;
    end else if (m_axis_tready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {rej_q, date_q.leap, date_q.year, date_q.month,
                            date_q.day, date_q.hour};

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (date_q.month >= MonthJan) && (date_q.month <= MonthDec))
    else $error("month register out of range");

  a_hour_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.hour <= HourLast)
    else $error("hour register out of range");

  a_year_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    date_q.year != '0)
    else $error("year register is zero");

  a_tick_not_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (in_mode_q == MODE_TICK)) |=> (out_vld_q && !rej_q))
    else $error("tick request flagged as rejected");

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the hour calendar counter. Ticks and loads go in on
// the input stream, a calendar predictor in the bench works out each date,
// and every output date is compared field by field in order of arrival.
// Directed requests cover rollovers, leap years, year wrap and rejected
// loads. Random traffic then runs under several idle and stall patterns.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ghcc_pkg::*;

  typedef struct packed {
    logic              rej;
    logic              leap;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [HourW-1:0]  hour;
  } cal_date_t;

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [31:0] s_data = '0;
  logic        s_user = MODE_TICK;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [31:0] m_data;

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatch_count = 0;

  int unsigned cal_hour;
  int unsigned cal_day;
  int unsigned cal_month;
  int unsigned cal_year;

  cal_date_t expected_dates[$];

  gregorian_hour_calendar_counter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic bit gregorian_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
    if (m == 2) return gregorian_leap(y) ? 29 : 28;
    if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
    return 31;
  endfunction

  // advances the bench's own calendar by one request
  function automatic cal_date_t predict_date(ghcc_mode_e m, int unsigned h, int unsigned d,
                                             int unsigned mo, int unsigned y);
    cal_date_t r;
    bit        rej;
    rej = 1'b0;
    if (m == MODE_TICK) begin
      if (cal_hour >= 23) begin
        cal_hour = 0;
        if (cal_day >= days_in_month(cal_month, cal_year)) begin
          cal_day = 1;
          if (cal_month >= 12) begin
            cal_month = 1;
            cal_year  = (cal_year >= 65535) ? 1 : cal_year + 1;
          end else begin
            cal_month++;
          end
        end else begin
          cal_day++;
        end
      end else begin
        cal_hour++;
      end
    end else begin
      if (h <= 23) cal_hour = h; else rej = 1'b1;
      if (y != 0) cal_year = y; else rej = 1'b1;
      if (mo >= 1 && mo <= 12) cal_month = mo; else rej = 1'b1;
      if (d >= 1 && d <= days_in_month(cal_month, cal_year)) cal_day = d;
      else rej = 1'b1;
    end
    r.hour  = cal_hour[HourW-1:0];
    r.day   = cal_day[DayW-1:0];
    r.month = cal_month[MonthW-1:0];
    r.year  = cal_year[YearW-1:0];
    r.leap  = gregorian_leap(cal_year);
    r.rej   = rej;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // one request, held until accepted; valid stays high for a back-to-back request
  task automatic send_request(ghcc_mode_e m, int unsigned h, int unsigned d,
                              int unsigned mo, int unsigned y);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= m;
    s_data  <= {2'b00, y[15:0], mo[3:0], d[4:0], h[4:0]};
    do @(posedge clk_i); while (!s_ready);
    expected_dates.push_back(predict_date(m, h, d, mo, y));
  endtask

  task automatic send_tick();
    send_request(MODE_TICK, $urandom_range(31), $urandom_range(31), $urandom_range(15),
                 $urandom_range(65535));
  endtask

  always @(posedge clk_i) begin
    m_ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    cal_date_t got;
    cal_date_t want;
    if (rst_ni && m_valid && m_ready) begin
      got = m_data;
      if (expected_dates.size() == 0) begin
        report_mismatch("unexpected result, tdata", m_data, 0);
      end else begin
        want = expected_dates.pop_front();
        if (got.hour  != want.hour)  report_mismatch("cur_hour", got.hour, want.hour);
        if (got.day   != want.day)   report_mismatch("cur_day", got.day, want.day);
        if (got.month != want.month) report_mismatch("cur_month", got.month, want.month);
        if (got.year  != want.year)  report_mismatch("cur_year", got.year, want.year);
        if (got.leap  != want.leap)  report_mismatch("is_leap", got.leap, want.leap);
        if (got.rej   != want.rej)   report_mismatch("load_rejected", got.rej, want.rej);
      end
    end
  end

  task automatic test_rollovers();
    send_tick();
    send_request(MODE_LOAD, 23, 31, 12, 65535);
    send_tick();
    send_request(MODE_LOAD, 23, 28, 2, 2000);
    send_tick();
    send_request(MODE_LOAD, 23, 28, 2, 1900);
    send_tick();
    send_request(MODE_LOAD, 23, 29, 2, 2024);
    send_tick();
    send_request(MODE_LOAD, 23, 30, 4, 2023);
    send_tick();
  endtask

  task automatic test_load_checks();
    send_request(MODE_LOAD, 24, 10, 5, 2010);
    send_request(MODE_LOAD, 31, 31, 15, 65535);
    send_request(MODE_LOAD, 0, 0, 0, 0);
    send_request(MODE_LOAD, 5, 15, 13, 300);
    send_request(MODE_LOAD, 5, 31, 4, 2001);
    send_request(MODE_LOAD, 5, 29, 2, 2100);
    // day kept past the new month's end, then rolled straight to the 1st
    send_request(MODE_LOAD, 23, 31, 1, 2023);
    send_request(MODE_LOAD, 23, 0, 2, 2023);
    send_tick();
  endtask

  function automatic int unsigned pick_year();
    unique case ($urandom_range(5))
      0: return 65535;
      1: return $urandom_range(163) * 400;
      2: return $urandom_range(655) * 100;
      3: return $urandom_range(16383) * 4;
      default: return $urandom_range(65535);
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned count);
    int unsigned h;
    int unsigned d;
    int unsigned mo;
    int unsigned y;
    int unsigned pick;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        send_tick();
      end else if (pick < 80) begin
        // well-formed load, mostly close to a rollover
        y  = pick_year();
        if (y == 0) y = 1;
        mo = $urandom_range(1, 12);
        h  = $urandom_range(1) ? 23 : $urandom_range(23);
        d  = $urandom_range(1) ? days_in_month(mo, y) : $urandom_range(1, days_in_month(mo, y));
        send_request(MODE_LOAD, h, d, mo, y);
      end else begin
        send_request(MODE_LOAD, $urandom_range(31), $urandom_range(31), $urandom_range(15),
                     pick_year());
      end
    end
  endtask

  initial begin
    cal_hour  = 0;
    cal_day   = 1;
    cal_month = 1;
    cal_year  = 1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_rollovers();
    test_load_checks();
    test_random_traffic(0, 0, 280);
    test_random_traffic(84, 0, 280);
    test_random_traffic(0, 84, 280);
    test_random_traffic(11, 11, 290);
    s_valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && expected_dates.size() == 0) begin
      $display("[gregorian_hour_calendar_counter] OK");
    end else begin
      $display("[gregorian_hour_calendar_counter] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[gregorian_hour_calendar_counter] ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
sv/ghcc_pkg.sv
sv/ghcc_step.sv
sv/gregorian_hour_calendar_counter.sv
sim/tb.sv
